// File: src/tcapq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcapq_pkg
// shared types, codes and defaults of the three class aging priority queue
// ----------------------------------------------------------------------------
package tcapq_pkg;

  localparam int TCAPQ_QUEUE_DEPTH = 16;
  localparam int CLASS_COUNT       = 3;

  localparam int ID_W   = 16;
  localparam int TS_W   = 32;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;
  localparam int ST_W   = 2;
  localparam int CLS_W  = 2;

  // request types
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_SERVE   = 1'b1;

  // class codes
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_NONE = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [ST_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [ST_W-1:0] ST_GRANTED  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MID_AGE  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LOW_AGE  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_HIGH_SVC = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MID_SVC  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LOW_SVC  = 3'd4;

  // configuration reset values
  localparam logic [CFG_W-1:0] RST_MID_AGE  = 16'd30;
  localparam logic [CFG_W-1:0] RST_LOW_AGE  = 16'd60;
  localparam logic [CFG_W-1:0] RST_HIGH_SVC = 16'd5;
  localparam logic [CFG_W-1:0] RST_MID_SVC  = 16'd5;
  localparam logic [CFG_W-1:0] RST_LOW_SVC  = 16'd5;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
  } tcapq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } tcapq_sts_t;

endpackage
`default_nettype wire

// File: src/tcapq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcapq_ctrl
// sequencer: takes one item, then executes it once the result register is free
// ----------------------------------------------------------------------------
module tcapq_ctrl
  import tcapq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire tcapq_sts_t sts,
  output tcapq_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    in_stall   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/tcapq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcapq_dpath
// class queues, head read registers, aging arbitration and result register
// ----------------------------------------------------------------------------
module tcapq_dpath
  import tcapq_pkg::*;
#(
  parameter int QUEUE_DEPTH = TCAPQ_QUEUE_DEPTH
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcapq_cmd_t        cmd,
  output tcapq_sts_t             sts,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_req_type,
  input  wire logic [CLS_W-1:0]  in_req_class,
  input  wire logic [ID_W-1:0]   in_req_id,
  input  wire logic [TS_W-1:0]   in_time_stamp,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ST_W-1:0]        out_status,
  output logic [CLS_W-1:0]       out_grant_class,
  output logic [ID_W-1:0]        out_grant_id,
  output logic [CFG_W-1:0]       out_grant_service_time
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0] FULL_OCC = OW'(QUEUE_DEPTH);

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [CFG_W-1:0] mid_age_r, low_age_r, high_svc_r, mid_svc_r, low_svc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_age_r  <= RST_MID_AGE;
      low_age_r  <= RST_LOW_AGE;
      high_svc_r <= RST_HIGH_SVC;
      mid_svc_r  <= RST_MID_SVC;
      low_svc_r  <= RST_LOW_SVC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MID_AGE:  mid_age_r  <= cfg_data;
        REG_LOW_AGE:  low_age_r  <= cfg_data;
        REG_HIGH_SVC: high_svc_r <= cfg_data;
        REG_MID_SVC:  mid_svc_r  <= cfg_data;
        REG_LOW_SVC:  low_svc_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  logic             req_type_r;
  logic [CLS_W-1:0] req_class_r;
  logic [ID_W-1:0]  req_id_r;
  logic [TS_W-1:0]  ts_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r  <= in_req_type;
      req_class_r <= in_req_class;
      req_id_r    <= in_req_id;
      ts_r        <= in_time_stamp;
    end
  end

  // queue pointers and occupancy
  logic [AW-1:0] rd_ptr_r  [CLASS_COUNT];
  logic [AW-1:0] rd_ptr_nxt[CLASS_COUNT];
  logic [AW-1:0] wr_ptr_r  [CLASS_COUNT];
  logic [AW-1:0] wr_ptr_nxt[CLASS_COUNT];
  logic [OW-1:0] occ_r     [CLASS_COUNT];
  logic [OW-1:0] occ_nxt   [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] wr_en;
  logic [CLASS_COUNT-1:0] rd_en;
  logic [CLASS_COUNT-1:0] nz;

  // head registers, read every cycle from the head slots
  logic [ID_W-1:0] id_head_r [CLASS_COUNT];
  logic [TS_W-1:0] arr_mid_r;
  logic [TS_W-1:0] arr_low_r;

  for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_idq
    logic [ID_W-1:0] id_mem [QUEUE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en[c]) begin
        id_mem[wr_ptr_r[c]] <= req_id_r;
      end
      id_head_r[c] <= id_mem[rd_ptr_r[c]];
    end
  end

  logic [TS_W-1:0] arr_mem_mid [QUEUE_DEPTH];
  logic [TS_W-1:0] arr_mem_low [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en[1]) begin
      arr_mem_mid[wr_ptr_r[1]] <= ts_r;
    end
    arr_mid_r <= arr_mem_mid[rd_ptr_r[1]];
  end

  always_ff @(posedge clk) begin
    if (wr_en[2]) begin
      arr_mem_low[wr_ptr_r[2]] <= ts_r;
    end
    arr_low_r <= arr_mem_low[rd_ptr_r[2]];
  end

  // arbitration
  logic [TS_W-1:0]  age_mid, age_low;
  logic             mid_aged, low_aged;
  logic             enq_ok, any_wait;
  logic [CLS_W-1:0] win;

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      nz[c] = (occ_r[c] != '0);
    end
    age_mid  = ts_r - arr_mid_r;
    age_low  = ts_r - arr_low_r;
    mid_aged = nz[1] && (age_mid >= {{(TS_W-CFG_W){1'b0}}, mid_age_r});
    low_aged = nz[2] && (age_low >= {{(TS_W-CFG_W){1'b0}}, low_age_r});
    any_wait = |nz;
    if (nz[0]) begin
      win = mid_aged ? CLS_MID : (low_aged ? CLS_LOW : CLS_HIGH);
    end else if (nz[1]) begin
      win = low_aged ? CLS_LOW : CLS_MID;
    end else begin
      win = CLS_LOW;
    end
    case (req_class_r)
      CLS_HIGH: enq_ok = (occ_r[0] != FULL_OCC);
      CLS_MID:  enq_ok = (occ_r[1] != FULL_OCC);
      CLS_LOW:  enq_ok = (occ_r[2] != FULL_OCC);
      default:  enq_ok = 1'b0;
    endcase
  end

  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      wr_en[c] = cmd.exec && (req_type_r == REQ_ENQUEUE) && enq_ok &&
                 (req_class_r == CLS_W'(c));
      rd_en[c] = cmd.exec && (req_type_r == REQ_SERVE) && any_wait &&
                 (win == CLS_W'(c));
      rd_ptr_nxt[c] = rd_ptr_r[c];
      wr_ptr_nxt[c] = wr_ptr_r[c];
      occ_nxt[c]    = occ_r[c];
      if (wr_en[c]) begin
        wr_ptr_nxt[c] = bump(wr_ptr_r[c]);
        occ_nxt[c]    = occ_r[c] + 1'b1;
      end else if (rd_en[c]) begin
        rd_ptr_nxt[c] = bump(rd_ptr_r[c]);
        occ_nxt[c]    = occ_r[c] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        rd_ptr_r[c] <= '0;
        wr_ptr_r[c] <= '0;
        occ_r[c]    <= '0;
      end
    end else begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        rd_ptr_r[c] <= rd_ptr_nxt[c];
        wr_ptr_r[c] <= wr_ptr_nxt[c];
        occ_r[c]    <= occ_nxt[c];
      end
    end
  end

  // result register
  logic             out_valid_r;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [CLS_W-1:0] gcls_r, gcls_nxt;
  logic [ID_W-1:0]  gid_r, gid_nxt;
  logic [CFG_W-1:0] gsvc_r, gsvc_nxt;

  always_comb begin
    status_nxt = ST_ENQUEUED;
    gcls_nxt   = CLS_HIGH;
    gid_nxt    = '0;
    gsvc_nxt   = '0;
    if (req_type_r == REQ_ENQUEUE) begin
      status_nxt = enq_ok ? ST_ENQUEUED : ST_DROPPED;
    end else if (!any_wait) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_GRANTED;
      gcls_nxt   = win;
      case (win)
        CLS_HIGH: begin
          gid_nxt  = id_head_r[0];
          gsvc_nxt = high_svc_r;
        end
        CLS_MID: begin
          gid_nxt  = id_head_r[1];
          gsvc_nxt = mid_svc_r;
        end
        default: begin
          gid_nxt  = id_head_r[2];
          gsvc_nxt = low_svc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      gcls_r   <= gcls_nxt;
      gid_r    <= gid_nxt;
      gsvc_r   <= gsvc_nxt;
    end
  end

  assign sts.out_busy           = out_valid_r && out_stall;
  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_grant_class        = gcls_r;
  assign out_grant_id           = gid_r;
  assign out_grant_service_time = gsvc_r;

endmodule
`default_nettype wire

// File: src/three_class_aging_priority_queue.sv
// flow: a result is presented from the result register once its item has been
//   latched and executed; execution waits while that register holds an untaken result
// intake: a new item is taken only after the last one has executed; in_stall
//   stays high while the sequencer waits to execute the latched item
// reset: synchronous, active low; queues empty, no result valid and configuration
//   registers at their defaults; queue memories, latched item and result data are not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_aging_priority_queue
// three class fifo queues served by strict priority with aging of middle and
// low heads
// ----------------------------------------------------------------------------
module three_class_aging_priority_queue
  import tcapq_pkg::*;
#(
  parameter int QUEUE_DEPTH = TCAPQ_QUEUE_DEPTH
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_req_type,
  input  wire logic [CLS_W-1:0]  in_req_class,
  input  wire logic [ID_W-1:0]   in_req_id,
  input  wire logic [TS_W-1:0]   in_time_stamp,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ST_W-1:0]        out_status,
  output logic [CLS_W-1:0]       out_grant_class,
  output logic [ID_W-1:0]        out_grant_id,
  output logic [CFG_W-1:0]       out_grant_service_time
);

  tcapq_cmd_t cmd;
  tcapq_sts_t sts;

  tcapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcapq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_req_type            (in_req_type),
    .in_req_class           (in_req_class),
    .in_req_id              (in_req_id),
    .in_time_stamp          (in_time_stamp),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_grant_class        (out_grant_class),
    .out_grant_id           (out_grant_id),
    .out_grant_service_time (out_grant_service_time)
  );

endmodule
`default_nettype wire
